// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check of a plain property, idle while reset is asserted
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: label");

// clocked check of an implication within the same cycle
`define ASSERT_IMPL(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: label");

`endif

// ----- src/ial_pkg.sv -----
`default_nettype none

package ial_pkg;

    localparam int POS_W = 9;
    localparam int DATA_W = 32;
    localparam int OP_W = 2;
    localparam int STAT_W = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SHIFT,
        ST_DEL_SHIFT,
        ST_FLUSH,
        ST_INS_NEW,
        ST_RD_WAIT
    } state_t;

endpackage

`default_nettype wire

// ----- src/indexed_array_insert_delete.sv -----
// sequence: a read goes through ST_RD_WAIT; an insert walks ST_INS_SHIFT, ST_FLUSH and ST_INS_NEW,
// an append at the end only ST_INS_NEW; a delete walks ST_DEL_SHIFT and ST_FLUSH; the last entry,
// a bad position, a full list or an unused code answer straight from idle
// throughput: one beat in flight at a time, the shift loop moves one entry per cycle through
// the single list memory
// reset: asynchronous active low, list empty, no clearing pass; results cannot be stalled
`default_nettype none
`include "assert_macros.svh"

module indexed_array_insert_delete #(
    parameter int CAPACITY = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [ial_pkg::OP_W-1:0]            operation,
    input  wire logic [ial_pkg::POS_W-1:0]           position,
    input  wire logic signed [ial_pkg::DATA_W-1:0]   value,
    output logic                                     done,
    output logic [ial_pkg::STAT_W-1:0]               status,
    output logic signed [ial_pkg::DATA_W-1:0]        read_value,
    output logic [ial_pkg::POS_W-1:0]                entry_count
);

    // address width of the list memory and width of the entry count
    localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    // compare width wide enough for both the input position and the count
    localparam int CMPW = (CW > ial_pkg::POS_W) ? CW : ial_pkg::POS_W;

    // sequencer state
    ial_pkg::state_t state_reg, state_next;

    // control registers
    logic [CW-1:0] count_reg, count_next;
    logic          done_reg, done_next;
    logic          pend_reg, pend_next;   // a read word waits to be written back

    // payload registers
    logic [AW-1:0]                 rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]                 wr_addr_reg, wr_addr_next;
    logic [AW-1:0]                 pos_reg, pos_next;
    logic [ial_pkg::DATA_W-1:0]    val_reg, val_next;
    logic [ial_pkg::OP_W-1:0]      op_reg, op_next;
    logic [ial_pkg::STAT_W-1:0]    status_reg, status_next;
    logic [ial_pkg::DATA_W-1:0]    read_value_reg, read_value_next;

    // list memory, one write and one registered read per cycle
    logic [ial_pkg::DATA_W-1:0] mem [CAPACITY];
    logic [ial_pkg::DATA_W-1:0] mem_q;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [AW-1:0]              mem_raddr;
    logic [ial_pkg::DATA_W-1:0] mem_wdata;

    // decode of the incoming beat against the current count
    logic            accept;
    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic [AW-1:0]   pos_a;
    logic [AW-1:0]   last_a;
    logic            pos_lt_cnt;
    logic            pos_le_cnt;
    logic            pos_is_last;
    logic            list_full;
    logic            shifting;

    assign busy        = (state_reg != ial_pkg::ST_IDLE);
    assign accept      = start && !busy;
    assign pos_ext     = CMPW'(position);
    assign cnt_ext     = CMPW'(count_reg);
    assign pos_a       = AW'(position);
    // last occupied slot, only meaningful while the list is not empty
    assign last_a      = AW'(count_reg - CW'(1));
    assign pos_lt_cnt  = pos_ext < cnt_ext;
    assign pos_le_cnt  = pos_ext <= cnt_ext;
    assign pos_is_last = pos_ext == (cnt_ext - CMPW'(1));
    assign list_full   = count_reg == CW'(CAPACITY);
    // shift loop or its trailing write-back
    assign shifting    = (state_reg == ial_pkg::ST_INS_SHIFT)
                         || (state_reg == ial_pkg::ST_DEL_SHIFT)
                         || (state_reg == ial_pkg::ST_FLUSH);

    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    // count already holds the value after the operation while done is high
    assign entry_count = ial_pkg::POS_W'(count_reg);

    // memory: insert shifts walk downward (read i, write i + 1 in the next cycle) and delete
    // shifts walk upward (read i, write i - 1), so a write never hits the address being read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ial_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (operation == ial_pkg::OP_INSERT && pos_le_cnt && !list_full)
                    begin
                        // append at the end needs no shift
                        state_next = (pos_ext == cnt_ext) ? ial_pkg::ST_INS_NEW
                                                          : ial_pkg::ST_INS_SHIFT;
                    end
                    else if (operation == ial_pkg::OP_DELETE && pos_lt_cnt)
                    begin
                        // removing the last entry needs no shift
                        state_next = pos_is_last ? ial_pkg::ST_IDLE : ial_pkg::ST_DEL_SHIFT;
                    end
                    else if (operation == ial_pkg::OP_READ && pos_lt_cnt)
                    begin
                        state_next = ial_pkg::ST_RD_WAIT;
                    end
                    else
                    begin
                        state_next = ial_pkg::ST_IDLE;
                    end
                end
            end
            ial_pkg::ST_INS_SHIFT:
            begin
                if (rd_ptr_reg == pos_reg)
                begin
                    state_next = ial_pkg::ST_FLUSH;
                end
            end
            ial_pkg::ST_DEL_SHIFT:
            begin
                if (rd_ptr_reg == last_a)
                begin
                    state_next = ial_pkg::ST_FLUSH;
                end
            end
            ial_pkg::ST_FLUSH:
            begin
                state_next = (op_reg == ial_pkg::OP_INSERT) ? ial_pkg::ST_INS_NEW
                                                            : ial_pkg::ST_IDLE;
            end
            ial_pkg::ST_INS_NEW:
            begin
                state_next = ial_pkg::ST_IDLE;
            end
            ial_pkg::ST_RD_WAIT:
            begin
                state_next = ial_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ial_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath, memory controls and result
    always_comb
    begin
        count_next      = count_reg;
        done_next       = 1'b0;
        pend_next       = 1'b0;
        rd_ptr_next     = rd_ptr_reg;
        wr_addr_next    = wr_addr_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        op_next         = op_reg;
        status_next     = status_reg;
        read_value_next = read_value_reg;

        // pending write-back of the word read in the previous cycle
        mem_we    = pend_reg;
        mem_waddr = wr_addr_reg;
        mem_wdata = mem_q;
        mem_raddr = rd_ptr_reg;

        unique case (state_reg)
            ial_pkg::ST_IDLE:
            begin
                mem_raddr = pos_a;
                if (accept)
                begin
                    op_next  = operation;
                    pos_next = pos_a;
                    val_next = value;
                    unique case (operation)
                        ial_pkg::OP_INSERT:
                        begin
                            // position checked before fullness
                            priority if (!pos_le_cnt)
                            begin
                                done_next       = 1'b1;
                                status_next     = ial_pkg::STAT_RANGE;
                                read_value_next = '0;
                            end
                            else if (list_full)
                            begin
                                done_next       = 1'b1;
                                status_next     = ial_pkg::STAT_FULL;
                                read_value_next = '0;
                            end
                            else
                            begin
                                rd_ptr_next = last_a;
                            end
                        end
                        ial_pkg::OP_DELETE:
                        begin
                            priority if (!pos_lt_cnt)
                            begin
                                done_next       = 1'b1;
                                status_next     = ial_pkg::STAT_RANGE;
                                read_value_next = '0;
                            end
                            else if (pos_is_last)
                            begin
                                count_next      = count_reg - CW'(1);
                                done_next       = 1'b1;
                                status_next     = ial_pkg::STAT_DONE;
                                read_value_next = '0;
                            end
                            else
                            begin
                                rd_ptr_next = pos_a + AW'(1);
                            end
                        end
                        ial_pkg::OP_READ:
                        begin
                            if (!pos_lt_cnt)
                            begin
                                done_next       = 1'b1;
                                status_next     = ial_pkg::STAT_RANGE;
                                read_value_next = '0;
                            end
                        end
                        default:
                        begin
                            // unused code
                            done_next       = 1'b1;
                            status_next     = ial_pkg::STAT_RANGE;
                            read_value_next = '0;
                        end
                    endcase
                end
            end
            ial_pkg::ST_INS_SHIFT:
            begin
                pend_next    = 1'b1;
                wr_addr_next = rd_ptr_reg + AW'(1);
                rd_ptr_next  = rd_ptr_reg - AW'(1);
            end
            ial_pkg::ST_DEL_SHIFT:
            begin
                pend_next    = 1'b1;
                wr_addr_next = rd_ptr_reg - AW'(1);
                rd_ptr_next  = rd_ptr_reg + AW'(1);
            end
            ial_pkg::ST_FLUSH:
            begin
                if (op_reg != ial_pkg::OP_INSERT)
                begin
                    count_next      = count_reg - CW'(1);
                    done_next       = 1'b1;
                    status_next     = ial_pkg::STAT_DONE;
                    read_value_next = '0;
                end
            end
            ial_pkg::ST_INS_NEW:
            begin
                mem_we          = 1'b1;
                mem_waddr       = pos_reg;
                mem_wdata       = val_reg;
                count_next      = count_reg + CW'(1);
                done_next       = 1'b1;
                status_next     = ial_pkg::STAT_DONE;
                read_value_next = '0;
            end
            ial_pkg::ST_RD_WAIT:
            begin
                done_next       = 1'b1;
                status_next     = ial_pkg::STAT_DONE;
                read_value_next = mem_q;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ial_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            pend_reg  <= pend_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        rd_ptr_reg     <= rd_ptr_next;
        wr_addr_reg    <= wr_addr_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        op_reg         <= op_next;
        status_reg     <= status_next;
        read_value_reg <= read_value_next;
    end

    // a result beat only shows once the sequencer is back to idle
    `ASSERT_IMPL(a_done_idle, done_reg, !busy)
    // write-back only happens right behind a shift read
    `ASSERT_IMPL(a_pend_shift, pend_reg, shifting)
    // count stays within the list size
    `ASSERT_ALWAYS(a_count_cap, count_reg <= CW'(CAPACITY))
    // a beat that returns straight to idle answers in the next cycle
    `ASSERT_IMPL(a_quick_answer, $past(rst_n) && $past(accept) && !busy, done_reg)

endmodule

`default_nettype wire

// ----- bench/tb_indexed_array_insert_delete.sv -----
`timescale 1ns / 100ps

module tb_indexed_array_insert_delete;

    import ial_pkg::*;

    localparam int CAPACITY   = 256;
    // slowest run: ~420 beats, each up to a full-length shift plus the largest random gap
    localparam int CYCLE_LIMIT = 1_000_000;
    // quiet time after the last answer, longer than the slowest shift
    localparam int TAIL_CYCLES = CAPACITY + 8;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [POS_W-1:0] POS_TOP = '1;

    // one command beat as queued for the driver
    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] word;
        logic                     drain;   // wait for every answer before sending
    } cmd_beat_t;

    // one answer beat as the list should report it
    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] read_value;
        logic [POS_W-1:0]         entry_count;
    } answer_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [OP_W-1:0]          operation = '0;
    logic [POS_W-1:0]         position = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     busy;
    logic                     done;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         entry_count;

    // commands waiting to be sent, answers waiting to arrive
    cmd_beat_t pending_cmds[$];
    answer_t   expected_answers[$];

    // shadow copy of the list, advanced on every accepted command
    logic signed [DATA_W-1:0] shadow_list[CAPACITY];
    int                       shadow_size = 0;

    // list size as the command generator plans it, ahead of the hardware
    int plan_size = 0;

    int failures = 0;
    int cycle_count = 0;

    // sender burst shaping
    int burst_left = 0;
    int gap_left = 0;

    indexed_array_insert_delete #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .position(position),
        .value(value),
        .done(done),
        .status(status),
        .read_value(read_value),
        .entry_count(entry_count)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // apply one command to the shadow list and return what the block must answer
    function automatic answer_t apply_list_cmd(logic [OP_W-1:0] opcode, logic [POS_W-1:0] pos,
                                               logic signed [DATA_W-1:0] word);
        answer_t ans;
        ans.status = STAT_RANGE;
        ans.read_value = '0;
        case (opcode)
            OP_INSERT:
            begin
                // position checked before fullness
                if (pos > shadow_size)
                    ans.status = STAT_RANGE;
                else if (shadow_size >= CAPACITY)
                    ans.status = STAT_FULL;
                else
                begin
                    for (int i = shadow_size; i > pos; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos] = word;
                    shadow_size++;
                    ans.status = STAT_DONE;
                end
            end
            OP_DELETE:
            begin
                if (pos < shadow_size)
                begin
                    for (int i = pos; i + 1 < shadow_size; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_size--;
                    ans.status = STAT_DONE;
                end
            end
            OP_READ:
            begin
                if (pos < shadow_size)
                begin
                    ans.read_value = shadow_list[pos];
                    ans.status = STAT_DONE;
                end
            end
            default:
            begin
                // unused code: list untouched, range status
                ans.status = STAT_RANGE;
            end
        endcase
        ans.entry_count = shadow_size[POS_W-1:0];
        return ans;
    endfunction

    // queue a command and track the planned list size so later positions can be aimed
    task automatic queue_cmd(logic [OP_W-1:0] opcode, int pos, logic signed [DATA_W-1:0] word,
                             logic drain);
        cmd_beat_t cmd;
        cmd.opcode = opcode;
        cmd.pos = pos[POS_W-1:0];
        cmd.word = word;
        cmd.drain = drain;
        pending_cmds.push_back(cmd);
        if (opcode == OP_INSERT && cmd.pos <= plan_size && plan_size < CAPACITY)
            plan_size++;
        else if (opcode == OP_DELETE && cmd.pos < plan_size)
            plan_size--;
    endtask

    // random data word, leaning on the extremes now and then
    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(15, 0))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // position that misses the list: just past the end, the top code, or anything
    function automatic int pick_bad_pos();
        case ($urandom_range(2, 0))
            0: return (plan_size + 1 <= int'(POS_TOP)) ? plan_size + 1 : int'(POS_TOP);
            1: return int'(POS_TOP);
            default: return $urandom_range(int'(POS_TOP), 0);
        endcase
    endfunction

    // junk beat: unused code or a random position with any operation
    task automatic queue_noise();
        if ($urandom_range(1, 0) == 0)
            queue_cmd(OP_UNUSED, $urandom_range(int'(POS_TOP), 0), pick_word(), 1'b0);
        else
            queue_cmd(2'($urandom_range(2, 0)), pick_bad_pos(), pick_word(), 1'b0);
    endtask

    // mixed traffic; delete_pct sets how hard the list is drained
    task automatic queue_mixed(int n_cmds, int delete_pct);
        int roll;
        for (int k = 0; k < n_cmds; k++)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 10)
                queue_noise();
            else if (roll < 10 + delete_pct)
            begin
                if (plan_size > 0)
                    queue_cmd(OP_DELETE, $urandom_range(plan_size - 1, 0), pick_word(), 1'b0);
                else
                    queue_cmd(OP_DELETE, 0, pick_word(), 1'b0);
            end
            else if (roll < 75)
                queue_cmd(OP_INSERT, $urandom_range(plan_size, 0), pick_word(), 1'b0);
            else if (plan_size > 0)
                queue_cmd(OP_READ, $urandom_range(plan_size - 1, 0), pick_word(), 1'b0);
            else
                queue_cmd(OP_READ, 0, pick_word(), 1'b0);
            // every so often let the block drain completely before the next beat
            if (k % 50 == 49)
                queue_cmd(OP_READ, pick_bad_pos(), pick_word(), 1'b1);
        end
    endtask

    // stimulus, reset and end of run
    initial
    begin
        int roll;
        int pos;

        // directed: empty list corners
        queue_cmd(OP_READ, 0, '0, 1'b0);
        queue_cmd(OP_DELETE, 0, '0, 1'b0);
        queue_cmd(OP_INSERT, 1, 32'sh1234_5678, 1'b0);     // past the end of an empty list
        queue_cmd(OP_UNUSED, 0, '1, 1'b0);
        // build a short list with the data extremes, ends and middle
        queue_cmd(OP_INSERT, 0, 32'sh7FFF_FFFF, 1'b0);
        queue_cmd(OP_INSERT, 1, 32'sh8000_0000, 1'b0);     // append at count
        queue_cmd(OP_INSERT, 0, '1, 1'b0);                 // push to the front
        queue_cmd(OP_INSERT, 1, '0, 1'b0);                 // into the middle
        for (int i = 0; i < 4; i++)
            queue_cmd(OP_READ, i, '0, 1'b0);
        queue_cmd(OP_READ, 4, '0, 1'b0);                   // read at count
        queue_cmd(OP_READ, POS_TOP, '0, 1'b0);
        queue_cmd(OP_INSERT, POS_TOP, 32'sh5A5A_A5A5, 1'b0);
        queue_cmd(OP_DELETE, 4, '0, 1'b0);                 // delete at count
        queue_cmd(OP_DELETE, 3, '0, 1'b0);                 // last entry
        queue_cmd(OP_DELETE, 0, '0, 1'b0);                 // first entry
        queue_cmd(OP_DELETE, 1, '0, 1'b0);
        queue_cmd(OP_READ, 0, '0, 1'b0);
        queue_cmd(OP_UNUSED, POS_TOP, 32'sh8000_0000, 1'b1);

        // fill to capacity with random positions, mostly inserts
        while (plan_size < CAPACITY)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 12)
                queue_cmd(OP_READ, $urandom_range(plan_size - 1, 0), pick_word(), 1'b0);
            else if (roll < 16)
                queue_noise();
            else
            begin
                if (roll < 32)
                    pos = plan_size;
                else if (roll < 45)
                    pos = 0;
                else
                    pos = $urandom_range(plan_size, 0);
                queue_cmd(OP_INSERT, pos, pick_word(), 1'b0);
            end
        end

        // full list corners
        queue_cmd(OP_INSERT, $urandom_range(CAPACITY, 0), pick_word(), 1'b1);
        queue_cmd(OP_INSERT, CAPACITY, pick_word(), 1'b0);     // good position, list full
        queue_cmd(OP_INSERT, CAPACITY + 1, pick_word(), 1'b0); // bad position wins over full
        queue_cmd(OP_READ, CAPACITY - 1, '0, 1'b0);
        queue_cmd(OP_READ, CAPACITY, '0, 1'b0);
        queue_cmd(OP_DELETE, 0, '0, 1'b0);
        queue_cmd(OP_INSERT, CAPACITY - 1, pick_word(), 1'b0); // back to full
        queue_cmd(OP_DELETE, CAPACITY - 1, '0, 1'b0);

        // drain hard, then balanced traffic
        queue_mixed(40, 50);
        queue_mixed(40, 25);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the queue to empty and every answer to come back
        while (pending_cmds.size() != 0 || start || expected_answers.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_answers.size() != 0)
        begin
            $error("%0d answers never arrived", expected_answers.size());
            failures++;
        end
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // driver: bursts of beats with random gaps, one beat in flight at a time
    always @(posedge clk)
    begin
        logic      accepted;
        cmd_beat_t nxt;
        accepted = start && !busy;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (accepted)
                expected_answers.push_back(apply_list_cmd(operation, position, value));
            // a beat still waiting on busy is held as it is
            if (!start || accepted)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() == 0)
                    start <= 1'b0;
                else if (pending_cmds[0].drain && expected_answers.size() != 0)
                    start <= 1'b0;      // hold off until the block has answered everything
                else
                begin
                    nxt = pending_cmds.pop_front();
                    start <= 1'b1;
                    operation <= nxt.opcode;
                    position <= nxt.pos;
                    value <= nxt.word;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        // end of burst: pick the next gap and burst length
                        gap_left = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(25, 1);
                        burst_left = $urandom_range(16, 1);
                    end
                end
            end
        end
    end

    // monitor: every done strobe is one answer beat, checked against the oldest expectation
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("answer beat with nothing expected: status %0d count %0d",
                       status, entry_count);
                failures++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if (status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, status);
                    failures++;
                end
                if (read_value !== want.read_value)
                begin
                    $error("read_value expected %0d actual %0d", want.read_value, read_value);
                    failures++;
                end
                if (entry_count !== want.entry_count)
                begin
                    $error("entry_count expected %0d actual %0d", want.entry_count,
                           entry_count);
                    failures++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
